>>> hdl/pmc_pkg.sv
// ----------------------------------------------------------------------------
// pmc_pkg: shared types and constants of the path matrix closure block
// Sizes of the adjacency store, field widths, codes of the stream fields and
// the control word that the sequencer hands to the datapath and output stage.
// ----------------------------------------------------------------------------
package pmc_pkg;

  // Largest vertex count the block is built for.
  localparam int MAX_VERTICES = 32;
  // At most 32 rows of 32 bits can be emitted.
  localparam int ROW_LIMIT = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int ADDR_W = $clog2(ROW_LIMIT);

  // Fixed field widths.
  localparam int VC_W  = 6;
  localparam int IDX_W = 5;
  localparam int ROW_W = 32;

  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  // Register index on the configuration port (paddr bit 2).
  localparam logic REG_VERTEX_COUNT = 1'b0;

  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;
  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_ROW   = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Adjacency read port address source.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_FROM,
    RD_ROW,
    RD_K
  } rd_sel_t;

  // Datapath register action of a step.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INIT_COMP,
    ACT_LOAD_P,
    ACT_POW_INIT,
    ACT_K_STEP,
    ACT_POW_END,
    ACT_ROW_INC,
    ACT_EDGE_WR
  } act_t;

  // Result produced by a step.
  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ACK_OK,
    EMIT_ACK_BAD,
    EMIT_ROW
  } emit_t;

  // Jump condition of a step; the jump goes to the step's target.
  typedef enum logic [3:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_IS_EDGE,
    COND_EDGE_BAD,
    COND_N_ONE,
    COND_K_MORE,
    COND_POW_MORE,
    COND_ROW_LAST
  } cond_t;

  typedef struct packed {
    logic    take_in;
    rd_sel_t rd_sel;
    act_t    act;
    emit_t   emit;
    cond_t   cond;
    step_t   target;
  } ctl_t;

  typedef struct packed {
    logic is_edge;
    logic edge_bad;
    logic n_one;
    logic k_more;
    logic pow_more;
    logic row_last;
  } stat_t;

endpackage

>>> hdl/path_matrix_closure.sv
// ----------------------------------------------------------------------------
// path_matrix_closure: reachability matrix of a directed graph
// Loads edges into an adjacency store and, on request, emits the transitive
// closure one row per vertex over a stream interface.
// ----------------------------------------------------------------------------
// Usage. Requests enter on the s_axis channel; s_axis_tuser selects an edge
// load (0) or a closure compute (1). Results leave on m_axis: an edge request
// gives one acknowledgement, a compute gives n rows with tlast on row n-1.
// vertex_count (APB register 0) sets n; it must be written only while idle, which the block does not enforce.
// The block works on one request at a time. An edge request reads the
// stored row of its source vertex, merges the edge into it and then gives
// its acknowledgement; a refused edge is acknowledged without the write.
// The time a compute takes, apart from receiver stalls, is set by the
// inner loop of the microprogram, which reads one adjacency row a cycle
// through the single read port of the store, n reads for each of the n-1
// powers of every row.
// Results pass through one output register, so the next request is taken
// while a result still waits; when the receiver stalls the sequencer holds
// on its next result step until the register frees up.
// A synchronous reset clears the adjacency valid bits at once, so the store
// reads as empty immediately, and returns vertex_count to 32.
// ----------------------------------------------------------------------------
module path_matrix_closure
  import pmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [4:0] edge_from, [9:5] edge_to, zero fill
  input  logic        s_axis_tuser,  // [0] op
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [0] edge_status, [5:1] row_index,
                                     // [37:6] row_bits, zero fill
  output logic        m_axis_tuser,  // [0] kind
  output logic        m_axis_tlast
);

  logic [VC_W-1:0]  vertex_count;
  ctl_t             ctl;
  stat_t            stat;
  logic             accept;
  logic             slot_free;
  logic             out_load;
  logic [IDX_W-1:0] dp_row;
  logic [ROW_W-1:0] dp_bits;

  logic             out_valid;
  logic             out_kind;
  logic             out_status;
  logic [IDX_W-1:0] out_row;
  logic [ROW_W-1:0] out_bits;
  logic             out_last;

  // The register index is paddr bit 2; writes elsewhere are ignored.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VERTEX_COUNT) begin
      prdata = {{(32 - VC_W){1'b0}}, vertex_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_VERTEX_COUNT)) begin
      vertex_count <= pwdata[VC_W-1:0];
    end
  end

  // A request is taken only in the idle step of the microprogram.
  assign s_axis_tready = ctl.take_in;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign slot_free = !out_valid || m_axis_tready;
  assign out_load  = (ctl.emit != EMIT_NONE) && slot_free;

  pmc_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (s_axis_tvalid),
    .slot_free (slot_free),
    .stat      (stat),
    .ctl       (ctl)
  );

  pmc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .accept       (accept),
    .in_op        (s_axis_tuser),
    .in_from      (s_axis_tdata[4:0]),
    .in_to        (s_axis_tdata[9:5]),
    .vertex_count (vertex_count),
    .stat         (stat),
    .row_index    (dp_row),
    .row_bits     (dp_bits)
  );

  // Output register: loaded by a result step whenever it is free or being
  // emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (ctl.emit)
        EMIT_ACK_OK: begin
          out_kind   <= KIND_ACK;
          out_status <= STATUS_OK;
          out_row    <= '0;
          out_bits   <= '0;
          out_last   <= 1'b1;
        end
        EMIT_ACK_BAD: begin
          out_kind   <= KIND_ACK;
          out_status <= STATUS_BAD;
          out_row    <= '0;
          out_bits   <= '0;
          out_last   <= 1'b1;
        end
        EMIT_ROW: begin
          out_kind   <= KIND_ROW;
          out_status <= STATUS_OK;
          out_row    <= dp_row;
          out_bits   <= dp_bits;
          out_last   <= stat.row_last;
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {2'b00, out_bits, out_row, out_status};

  // Only one request is in flight: the idle step is left on acceptance.
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(out_load && out_valid && !m_axis_tready))
    else $error("output register loaded while full and stalled");

  // Every acknowledgement closes its request.
  a_ack_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_ACK)) |-> m_axis_tlast)
    else $error("edge acknowledgement without last");

  // The last row of a compute returns the sequencer to idle.
  a_last_row_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && (ctl.emit == EMIT_ROW) && stat.row_last) |=> s_axis_tready)
    else $error("sequencer not idle after the final row");

endmodule

>>> hdl/pmc_sequencer.sv
// ----------------------------------------------------------------------------
// pmc_sequencer: microprogram store and step counter
// Holds the control program, evaluates its jump conditions and stalls on a
// result step while the output register cannot take the result.
// ----------------------------------------------------------------------------
module pmc_sequencer
  import pmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req,
  input  logic  slot_free,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_DISP = 4'd1;
  localparam step_t ST_C0   = 4'd2;
  localparam step_t ST_C1   = 4'd3;
  localparam step_t ST_C2   = 4'd4;
  localparam step_t ST_C3   = 4'd5;
  localparam step_t ST_C4   = 4'd6;
  localparam step_t ST_C5   = 4'd7;
  localparam step_t ST_EMIT = 4'd8;
  localparam step_t ST_NROW = 4'd9;
  localparam step_t ST_E0   = 4'd10;
  localparam step_t ST_E1   = 4'd11;
  localparam step_t ST_EOK  = 4'd12;
  localparam step_t ST_EBAD = 4'd13;

  function automatic ctl_t ucode(input step_t s);
    ctl_t w;
    w.take_in = 1'b0;
    w.rd_sel  = RD_NONE;
    w.act     = ACT_NONE;
    w.emit    = EMIT_NONE;
    w.cond    = COND_NEXT;
    w.target  = ST_IDLE;
    unique case (s)
      ST_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_REQ;
        w.target  = ST_IDLE;
      end
      ST_DISP: begin
        w.cond   = COND_IS_EDGE;
        w.target = ST_E0;
      end
      ST_C0: w.act = ACT_INIT_COMP;
      ST_C1: w.rd_sel = RD_ROW;
      ST_C2: begin
        w.act    = ACT_LOAD_P;
        w.cond   = COND_N_ONE;
        w.target = ST_EMIT;
      end
      ST_C3: w.act = ACT_POW_INIT;
      ST_C4: begin
        w.rd_sel = RD_K;
        w.act    = ACT_K_STEP;
        w.cond   = COND_K_MORE;
        w.target = ST_C4;
      end
      ST_C5: begin
        w.act    = ACT_POW_END;
        w.cond   = COND_POW_MORE;
        w.target = ST_C3;
      end
      ST_EMIT: begin
        w.emit   = EMIT_ROW;
        w.cond   = COND_ROW_LAST;
        w.target = ST_IDLE;
      end
      ST_NROW: begin
        w.act    = ACT_ROW_INC;
        w.cond   = COND_ALWAYS;
        w.target = ST_C1;
      end
      ST_E0: begin
        w.rd_sel = RD_FROM;
        w.cond   = COND_EDGE_BAD;
        w.target = ST_EBAD;
      end
      ST_E1: w.act = ACT_EDGE_WR;
      ST_EOK: begin
        w.emit   = EMIT_ACK_OK;
        w.cond   = COND_ALWAYS;
        w.target = ST_IDLE;
      end
      ST_EBAD: begin
        w.emit   = EMIT_ACK_BAD;
        w.cond   = COND_ALWAYS;
        w.target = ST_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  step_t step;
  step_t step_next;
  logic  jump;
  logic  hold;

  assign ctl = ucode(step);

  always_comb begin
    unique case (ctl.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_REQ:   jump = !req;
      COND_IS_EDGE:  jump = stat.is_edge;
      COND_EDGE_BAD: jump = stat.edge_bad;
      COND_N_ONE:    jump = stat.n_one;
      COND_K_MORE:   jump = stat.k_more;
      COND_POW_MORE: jump = stat.pow_more;
      COND_ROW_LAST: jump = stat.row_last;
      default:       jump = 1'b1;
    endcase
    // Result steps carry no datapath action, so holding one is harmless.
    hold = (ctl.emit != EMIT_NONE) && !slot_free;
    if (hold) begin
      step_next = step;
    end else if (jump) begin
      step_next = ctl.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> hdl/pmc_datapath.sv
// ----------------------------------------------------------------------------
// pmc_datapath: adjacency store and boolean power datapath
// Holds the adjacency rows with per-row valid bits, and the power, reach and
// accumulator rows of the row under computation, as driven by the control word.
// ----------------------------------------------------------------------------
module pmc_datapath
  import pmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  input  logic             accept,
  input  logic             in_op,
  input  logic [IDX_W-1:0] in_from,
  input  logic [IDX_W-1:0] in_to,
  input  logic [VC_W-1:0]  vertex_count,
  output stat_t            stat,
  output logic [IDX_W-1:0] row_index,
  output logic [ROW_W-1:0] row_bits
);

  logic [ROW_W-1:0]     adj_mem [ROW_LIMIT];
  logic [ROW_LIMIT-1:0] adj_vld;
  logic [ROW_W-1:0]     adj_rd;
  logic                 adj_rd_ok;
  logic [ADDR_W-1:0]    rd_addr;

  logic             op_reg;
  logic [IDX_W-1:0] from_reg;
  logic [IDX_W-1:0] to_reg;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] kd;
  logic             issue_d;
  logic [VC_W-1:0]  pw;
  logic [ROW_W-1:0] pmat;
  logic [ROW_W-1:0] reach;
  logic [ROW_W-1:0] acc;

  logic [VC_W-1:0]  n_eff;
  logic [VC_W-1:0]  n_less;
  logic [IDX_W-1:0] nm1;
  logic [VC_W-1:0]  pw_inc;
  logic [ROW_W-1:0] colmask;
  logic [ROW_W-1:0] adj_m;
  logic [ROW_W-1:0] acc_next;

  // Vertex count saturated into 1 .. ROW_LIMIT.
  always_comb begin
    priority if (vertex_count == '0) begin
      n_eff = VC_W'(1);
    end else if (vertex_count > VC_W'(ROW_LIMIT)) begin
      n_eff = VC_W'(ROW_LIMIT);
    end else begin
      n_eff = vertex_count;
    end
    n_less = n_eff - VC_W'(1);
    nm1    = n_less[IDX_W-1:0];
    pw_inc = pw + VC_W'(1);
    for (int j = 0; j < ROW_W; j++) begin
      colmask[j] = (VC_W'(j) < n_eff);
    end
    adj_m    = (adj_rd_ok ? adj_rd : '0) & colmask;
    acc_next = acc | ((issue_d && pmat[kd]) ? adj_m : '0);
  end

  always_comb begin
    unique case (ctl.rd_sel)
      RD_NONE: rd_addr = '0;
      RD_FROM: rd_addr = from_reg[ADDR_W-1:0];
      RD_ROW:  rd_addr = row[ADDR_W-1:0];
      RD_K:    rd_addr = k[ADDR_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  assign stat.is_edge  = (op_reg == OP_EDGE);
  assign stat.edge_bad = ({1'b0, from_reg} >= n_eff) || ({1'b0, to_reg} >= n_eff);
  assign stat.n_one    = (n_eff == VC_W'(1));
  assign stat.k_more   = (k != nm1);
  assign stat.pow_more = (pw_inc < n_eff);
  assign stat.row_last = (row == nm1);

  assign row_index = row;
  assign row_bits  = reach;

  // Adjacency memory: one registered read, one write per cycle. A new edge is
  // merged into the whole stored row, so edges beyond the current count stay.
  always_ff @(posedge clk) begin
    adj_rd <= adj_mem[rd_addr];
    if (ctl.act == ACT_EDGE_WR) begin
      adj_mem[from_reg[ADDR_W-1:0]] <= (adj_rd_ok ? adj_rd : '0) | (ROW_W'(1) << to_reg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      adj_vld   <= '0;
      adj_rd_ok <= 1'b0;
      issue_d   <= 1'b0;
    end else begin
      adj_rd_ok <= adj_vld[rd_addr];
      issue_d   <= (ctl.rd_sel == RD_K);
      if (ctl.act == ACT_EDGE_WR) begin
        adj_vld[from_reg[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    kd <= k;
    if (accept) begin
      op_reg   <= in_op;
      from_reg <= in_from;
      to_reg   <= in_to;
    end
    if (ctl.act == ACT_POW_INIT) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
    unique case (ctl.act)
      ACT_INIT_COMP: row <= '0;
      ACT_LOAD_P: begin
        pmat  <= adj_m;
        reach <= adj_m;
        pw    <= VC_W'(1);
      end
      ACT_POW_INIT: k <= '0;
      ACT_K_STEP:   k <= k + 1'b1;
      ACT_POW_END: begin
        pmat  <= acc_next;
        reach <= reach | acc_next;
        pw    <= pw_inc;
      end
      ACT_ROW_INC: row <= row + 1'b1;
      default: begin
      end
    endcase
  end

endmodule

>>> tb/sv/closure_tb_pkg.sv
// ----------------------------------------------------------------------------
// closure_tb_pkg: expected-result tracking for the path matrix closure bench
// Keeps a private copy of the vertex count and the adjacency store, works out
// the acknowledgement or reachability rows that each accepted request should
// produce, and compares them in order against what the block emits.
// ----------------------------------------------------------------------------
package closure_tb_pkg;
  import pmc_pkg::*;

  // Fields of one result, in the order they appear on the result stream.
  typedef struct packed {
    logic             kind;
    logic             edge_status;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
    logic             last;
  } closure_result_t;

  class closure_scoreboard;
    logic [VC_W-1:0]   vertex_count;
    logic [ROW_W-1:0]  adjacency [ROW_LIMIT];
    closure_result_t   awaited [$];
    int unsigned       edges_stored;
    int unsigned       edges_refused;
    int unsigned       computes;
    int unsigned       results_checked;
    int unsigned       mismatches;

    function new();
      vertex_count = VC_RESET;
      foreach (adjacency[i]) adjacency[i] = '0;
      edges_stored = 0;
      edges_refused = 0;
      computes = 0;
      results_checked = 0;
      mismatches = 0;
    endfunction

    // The register index is bit 2 of the byte address; other indices are ignored.
    function void note_register_write(logic [2:0] addr, logic [31:0] data);
      if (addr[2] == REG_VERTEX_COUNT)
        vertex_count = data[VC_W-1:0];
    endfunction

    // Vertex count as the block uses it: zero acts as one, and anything above
    // the row limit saturates.
    function int unsigned active_vertices();
      int unsigned v;
      v = vertex_count;
      if (v < 1) v = 1;
      if (v > ROW_LIMIT) v = ROW_LIMIT;
      return v;
    endfunction

    function int unsigned pending_count();
      return awaited.size();
    endfunction

    // Boolean matrix powers A .. A^n over the first n vertices, ORed together.
    function void predict_reach_rows(int unsigned n);
      logic [ROW_W-1:0] cols;
      logic [ROW_W-1:0] acc;
      logic [ROW_W-1:0] walk [ROW_LIMIT];
      logic [ROW_W-1:0] grown [ROW_LIMIT];
      logic [ROW_W-1:0] reach [ROW_LIMIT];
      closure_result_t  r;
      cols = '0;
      for (int i = 0; i < n; i++) cols[i] = 1'b1;
      for (int i = 0; i < n; i++) begin
        walk[i] = adjacency[i] & cols;
        reach[i] = walk[i];
      end
      for (int p = 2; p <= n; p++) begin
        for (int i = 0; i < n; i++) begin
          acc = '0;
          for (int k = 0; k < n; k++)
            if (walk[i][k]) acc |= adjacency[k] & cols;
          grown[i] = acc;
        end
        for (int i = 0; i < n; i++) begin
          walk[i] = grown[i];
          reach[i] |= walk[i];
        end
      end
      for (int i = 0; i < n; i++) begin
        r.kind = KIND_ROW;
        r.edge_status = STATUS_OK;
        r.row_index = IDX_W'(i);
        r.row_bits = reach[i];
        r.last = (i + 1 == n);
        awaited.push_back(r);
      end
    endfunction

    function void note_request(logic op, logic [IDX_W-1:0] from, logic [IDX_W-1:0] to);
      int unsigned     n;
      closure_result_t r;
      n = active_vertices();
      if (op == OP_COMPUTE) begin
        computes++;
        predict_reach_rows(n);
      end else begin
        r = '0;
        r.kind = KIND_ACK;
        r.last = 1'b1;
        if (from >= n || to >= n) begin
          r.edge_status = STATUS_BAD;
          edges_refused++;
        end else begin
          r.edge_status = STATUS_OK;
          adjacency[from][to] = 1'b1;
          edges_stored++;
        end
        awaited.push_back(r);
      end
    endfunction

    function void check_result(closure_result_t got);
      closure_result_t want;
      results_checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: result kind=%0d row=%0d bits=%h last=%0d with nothing awaited",
                   got.kind, got.row_index, got.row_bits, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"MISMATCH: expected kind=%0d status=%0d row=%0d bits=%h last=%0d, ",
                    "got kind=%0d status=%0d row=%0d bits=%h last=%0d"},
                   want.kind, want.edge_status, want.row_index, want.row_bits, want.last,
                   got.kind, got.edge_status, got.row_index, got.row_bits, got.last);
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for path_matrix_closure
// Drives edge-load and closure requests through the request stream, rewrites
// the vertex count between phases over APB, and checks every acknowledgement
// and reachability row against an in-order prediction of the expected rows.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmc_pkg::*;
  import closure_tb_pkg::*;

  // Byte address of the vertex count, and of an index that has no register.
  localparam logic [2:0] ADDR_VERTEX_COUNT = {REG_VERTEX_COUNT, 2'b00};
  localparam logic [2:0] ADDR_SPARE        = 3'd4;

  // Idling mixes, stepped through by the random phases.
  localparam int MIX_NONE     = 0;
  localparam int MIX_SENDER   = 1;
  localparam int MIX_RECEIVER = 2;
  localparam int MIX_BOTH     = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [4:0] edge_from, [9:5] edge_to, zero fill
  logic        s_axis_tuser = 1'b0; // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [0] edge_status, [5:1] row_index,
                                    // [37:6] row_bits, zero fill
  logic        m_axis_tuser;        // [0] kind
  logic        m_axis_tlast;

  // Percentages of cycles in which the sender holds back and the receiver
  // refuses a result. The main sequence changes them between phases.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  closure_scoreboard sb;

  path_matrix_closure dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // The receiver decides afresh at every falling edge whether it will take a
  // result, so stalls land on rows in every position of a closure.
  initial begin
    forever begin
      @(negedge clk);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Every result taken at a rising edge is checked against the oldest
  // expectation. The values read here are those from before the edge.
  always @(posedge clk) begin
    closure_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.edge_status = m_axis_tdata[0];
      got.row_index = m_axis_tdata[5:1];
      got.row_bits = m_axis_tdata[37:6];
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // Presents one request and returns at the edge where it was accepted. Each
  // call starts at a fresh falling edge, so valid is either lowered for a gap
  // or carries the new request, never both in one step.
  task automatic send_request(input logic op, input logic [4:0] from, input logic [4:0] to);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, to, from};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(op, from, to);
  endtask

  // A compute ignores the vertex fields, so they carry random content.
  task automatic send_compute();
    send_request(OP_COMPUTE, 5'($urandom), 5'($urandom));
  endtask

  // Withdraws the request stream and waits until every awaited result is in.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle then access cycle. The register only changes while
  // the block has nothing in flight, so the stream is drained first and the
  // bench then waits on so that the sequencer can return to its idle step.
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    drain_results();
    repeat (8) @(posedge clk);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.note_register_write(addr, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Upper bits of the data are random: only the low six bits are the register.
  task automatic set_vertex_count(input logic [5:0] count);
    write_register(ADDR_VERTEX_COUNT, {26'($urandom), count});
  endtask

  task automatic set_idling(input int mix);
    case (mix)
      MIX_SENDER: begin
        sender_idle_pct = 55;
        receiver_stall_pct = 0;
      end
      MIX_RECEIVER: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 55;
      end
      MIX_BOTH: begin
        sender_idle_pct = 9;
        receiver_stall_pct = 9;
      end
      default: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endtask

  // Timeout. The slowest correct run is dominated by the two closures at 32
  // vertices; this limit is several times the whole.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $display("Timed out with %0d results still awaited", sb.pending_count());
    $finish;
  end

  initial begin
    int unsigned  n;
    int unsigned  count;
    int unsigned  roll;
    logic [5:0]   vc;

    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- Directed part -----------------------------------------------------
    // Vertex count is at its reset value of 32. Edges at both ends of the
    // vertex range, a self loop, a duplicate, and alternating bit patterns.
    set_idling(MIX_NONE);
    send_request(OP_EDGE, 5'd0, 5'd31);
    send_request(OP_EDGE, 5'd31, 5'd0);
    send_request(OP_EDGE, 5'd31, 5'd31);
    send_request(OP_EDGE, 5'd0, 5'd31);
    send_request(OP_EDGE, 5'd10, 5'd21);
    send_request(OP_EDGE, 5'd21, 5'd10);
    send_compute();

    // Smallest graph: a single vertex, so either end at 1 is out of range.
    set_vertex_count(6'd1);
    send_request(OP_EDGE, 5'd0, 5'd0);
    send_request(OP_EDGE, 5'd0, 5'd1);
    send_request(OP_EDGE, 5'd1, 5'd0);
    send_compute();

    // A write to an index with no register must leave the count alone, and
    // a count of zero behaves as one.
    write_register(ADDR_SPARE, 32'h0000_0005);
    set_vertex_count(6'd0);
    send_request(OP_EDGE, 5'd1, 5'd1);
    send_compute();

    // Counts above the row limit saturate at 32, so vertex 31 is usable.
    set_vertex_count(6'd63);
    send_request(OP_EDGE, 5'd31, 5'd30);

    // Shrinking the count leaves the high edges in the store but out of the
    // closure. A chain 3 -> 2 -> 0 with the loop on 0 needs several powers.
    set_vertex_count(6'd4);
    send_request(OP_EDGE, 5'd4, 5'd0);
    send_request(OP_EDGE, 5'd3, 5'd4);
    send_request(OP_EDGE, 5'd3, 5'd2);
    send_request(OP_EDGE, 5'd2, 5'd0);
    send_compute();

    // --- Random part -------------------------------------------------------
    // Each phase picks a vertex count, loads mostly in-range edges with some
    // out-of-range noise, and closes with a compute. Small graphs keep the
    // closures short; one phase runs the full 32 vertices.
    for (int phase = 0; phase < 8; phase++) begin
      vc = (phase == 5) ? 6'd32 : 6'($urandom_range(2, 12));
      set_vertex_count(vc);
      set_idling(phase % 4);
      n = vc;
      count = $urandom_range(9, 13);
      for (int j = 0; j < count; j++) begin
        roll = $urandom_range(99);
        if (roll < 12)
          send_request(OP_EDGE, 5'($urandom), 5'($urandom));
        else if (roll < 20 && n <= 12)
          send_compute();
        else
          send_request(OP_EDGE, 5'($urandom_range(n - 1)), 5'($urandom_range(n - 1)));
        // Once in the run the sender holds off until the block has caught up.
        if (phase == 1 && j == count / 2)
          drain_results();
      end
      send_compute();
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d edge loads (%0d refused) and %0d closure computes, %0d results checked.",
             sb.edges_stored + sb.edges_refused, sb.edges_refused, sb.computes,
             sb.results_checked);
    $display("Vertex counts 0, 1, 4, 32, 63 and random small graphs, under four idling mixes.");
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
      $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending_count());
    end
    $finish;
  end

endmodule

>>> path_matrix_closure.f
hdl/pmc_pkg.sv
hdl/pmc_sequencer.sv
hdl/pmc_datapath.sv
hdl/path_matrix_closure.sv
tb/sv/closure_tb_pkg.sv
tb/sv/tb.sv
